[rtl/core/ssb_two_stage_mixer_demod_defines.svh]
// ============================================================================
// SSB demodulator assertion macros
// Shared property wrappers for the checker, clocked on aclk.
// ============================================================================
`ifndef SSB_TWO_STAGE_MIXER_DEMOD_DEFINES_SVH
`define SSB_TWO_STAGE_MIXER_DEMOD_DEFINES_SVH

// property checked only while out of reset
`define SSBD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ssbd assertion failed");

// property checked at every edge, reset included
`define SSBD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("ssbd assertion failed during reset");

`endif

[rtl/core/ssbd_pkg.sv]
// ============================================================================
// ssbd_pkg
// Widths, phase codes, register indexes and the sine table for the demod.
// ============================================================================
`timescale 1ns / 1ps

package ssbd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SINE_WIDTH   = 17;   // holds +/-32768
    localparam int SINE_FRAC    = 15;
    localparam int MIXED_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int PROD_WIDTH   = MIXED_WIDTH + SINE_WIDTH;
    localparam int ROUND_WIDTH  = PROD_WIDTH - SINE_FRAC;
    localparam int ROUND_HALF   = 1 << (SINE_FRAC - 1);

    localparam int CPHASE_WIDTH = 2;
    localparam int DPHASE_WIDTH = 4;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_USB_MODE       = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DIVIDER_EIGHTH = 1'd1;

    // quarter-rate carrier selections
    localparam logic [CPHASE_WIDTH-1:0] CP_POS_I = 2'd0;
    localparam logic [CPHASE_WIDTH-1:0] CP_NEG_Q = 2'd1;
    localparam logic [CPHASE_WIDTH-1:0] CP_NEG_I = 2'd2;
    localparam logic [CPHASE_WIDTH-1:0] CP_POS_Q = 2'd3;

    localparam logic [DPHASE_WIDTH-1:0] DSTEP_BASE = 4'd4;  // pi/2
    localparam logic [DPHASE_WIDTH-1:0] DOFF_DIV4  = 4'd2;  // pi/4
    localparam logic [DPHASE_WIDTH-1:0] DOFF_DIV8  = 4'd1;  // pi/8

    typedef struct packed {
        logic [CPHASE_WIDTH-1:0] carrier;
        logic [DPHASE_WIDTH-1:0] demod;
    } phase_t;

    // sin(k*pi/8) scaled by 2^15
    function automatic logic signed [SINE_WIDTH-1:0] sine_q15(
        input logic [DPHASE_WIDTH-1:0] ph
    );
        logic signed [SINE_WIDTH-1:0] s;
        case (ph)
            4'd0:    s = 17'sd0;
            4'd1:    s = 17'sd12540;
            4'd2:    s = 17'sd23170;
            4'd3:    s = 17'sd30274;
            4'd4:    s = 17'sd32768;
            4'd5:    s = 17'sd30274;
            4'd6:    s = 17'sd23170;
            4'd7:    s = 17'sd12540;
            4'd8:    s = 17'sd0;
            4'd9:    s = -17'sd12540;
            4'd10:   s = -17'sd23170;
            4'd11:   s = -17'sd30274;
            4'd12:   s = -17'sd32768;
            4'd13:   s = -17'sd30274;
            4'd14:   s = -17'sd23170;
            default: s = -17'sd12540;
        endcase
        return s;
    endfunction

    function automatic logic [DPHASE_WIDTH-1:0] demod_step(
        input logic usb,
        input logic div8
    );
        logic [DPHASE_WIDTH-1:0] off;
        off = div8 ? DOFF_DIV8 : DOFF_DIV4;
        return usb ? (DSTEP_BASE - off) : (DSTEP_BASE + off);
    endfunction

endpackage

[rtl/core/ssbd_mixer.sv]
// ============================================================================
// ssbd_mixer
// Quarter-rate select/negate, sine multiply, Q15 round and saturate.
// ============================================================================
`timescale 1ns / 1ps

module ssbd_mixer import ssbd_pkg::*; (
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
    input  phase_t                         phase,
    output logic signed [SAMPLE_WIDTH-1:0] audio_sample
);

    logic signed [MIXED_WIDTH-1:0] i_ext;
    logic signed [MIXED_WIDTH-1:0] q_ext;
    logic signed [MIXED_WIDTH-1:0] mixed;
    logic signed [SINE_WIDTH-1:0]  sine;
    logic signed [PROD_WIDTH-1:0]  product;
    logic signed [PROD_WIDTH-1:0]  biased;
    logic signed [ROUND_WIDTH-1:0] rounded;
    logic                          in_range;

    assign i_ext = MIXED_WIDTH'(i_sample);
    assign q_ext = MIXED_WIDTH'(q_sample);

    // one extra bit so negating the most negative sample is exact
    always_comb begin
        case (phase.carrier)
            CP_POS_I: mixed = i_ext;
            CP_NEG_Q: mixed = -q_ext;
            CP_NEG_I: mixed = -i_ext;
            default:  mixed = q_ext;
        endcase
    end

    assign sine    = sine_q15(phase.demod);
    assign product = PROD_WIDTH'(mixed) * PROD_WIDTH'(sine);
    assign biased  = product + PROD_WIDTH'(ROUND_HALF);
    assign rounded = biased[PROD_WIDTH-1:SINE_FRAC];

    // fits when all bits above the sample's sign bit match it
    assign in_range = (rounded[ROUND_WIDTH-1:SAMPLE_WIDTH-1] == '0) ||
                      (rounded[ROUND_WIDTH-1:SAMPLE_WIDTH-1] == '1);

    always_comb begin
        if (in_range) begin
            audio_sample = rounded[SAMPLE_WIDTH-1:0];
        end else if (rounded[ROUND_WIDTH-1]) begin
            audio_sample = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            audio_sample = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

endmodule

[rtl/core/ssb_two_stage_mixer_demod.sv]
// An accepted item reaches m_valid through the input register, then the result register.
// One item per cycle unless m_ready stalls it; the mixer in between is single-pass.
// A held result blocks the input only once the input register is also full, so
// one item can still be taken while the result waits.
// Reset (aresetn low, synchronous): both phases, both config bits and all valids clear.
`timescale 1ns / 1ps

module ssb_two_stage_mixer_demod import ssbd_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]      cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] s_q_sample,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_audio_sample
);

    logic                           usb_mode_reg;
    logic                           divider_eighth_reg;
    phase_t                         phase_reg;
    phase_t                         phase_next;

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] i_reg;
    logic signed [SAMPLE_WIDTH-1:0] q_reg;
    phase_t                         in_phase_reg;

    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] audio_reg;
    logic signed [SAMPLE_WIDTH-1:0] audio_next;

    logic                           s_accept;
    logic                           out_load;

    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign s_accept = s_valid && s_ready;

    // each item uses the phases held before it, then both advance
    assign phase_next.carrier = phase_reg.carrier + 1'b1;
    assign phase_next.demod   = phase_reg.demod +
                                demod_step(usb_mode_reg, divider_eighth_reg);

    ssbd_mixer u_mixer (
        .i_sample     (i_reg),
        .q_sample     (q_reg),
        .phase        (in_phase_reg),
        .audio_sample (audio_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usb_mode_reg       <= 1'b0;
            divider_eighth_reg <= 1'b0;
            phase_reg          <= '0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_USB_MODE:       usb_mode_reg       <= cfg_data[0];
                    CFG_DIVIDER_EIGHTH: divider_eighth_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                phase_reg    <= phase_next;
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            i_reg        <= s_i_sample;
            q_reg        <= s_q_sample;
            in_phase_reg <= phase_reg;
        end
        if (out_load && in_valid_reg) begin
            audio_reg <= audio_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_audio_sample = audio_reg;

endmodule

[rtl/core/ssbd_checker.sv]
// ============================================================================
// ssbd_checker
// Port-level checks on the demod handshakes, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "ssb_two_stage_mixer_demod_defines.svh"

module ssbd_checker import ssbd_pkg::*; (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_WIDTH-1:0] m_audio_sample
);

    // a stalled result holds its value
    `SSBD_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_audio_sample))

    // reset leaves no result pending
    `SSBD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

    // with no result pending the pipeline has room
    `SSBD_ASSERT(a_ready_when_empty, !m_valid |-> s_ready)

    // an item taken while the output is free reaches m_valid through the input and result registers
    `SSBD_ASSERT(a_latency, s_valid && s_ready && !m_valid |=> ##1 m_valid)

endmodule

bind ssb_two_stage_mixer_demod ssbd_checker u_ssbd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_audio_sample (m_audio_sample)
);
